// File: design/wbc_pkg.sv
// Shared types, sizes and command codes for the dictionary word-break checker.
// Used by wbc_match and the top module; depends on nothing else.
package wbc_pkg;

  localparam int MAX_WORDS    = 16;
  localparam int MAX_WORD_LEN = 16;
  localparam int MAX_TEXT     = 4096;

  localparam int SLOT_W = $clog2(MAX_WORDS);
  localparam int POS_W  = $clog2(MAX_WORD_LEN);
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W  = $clog2(MAX_TEXT + 1);
  localparam int ROW_W  = 8 * MAX_WORD_LEN;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_TEXT  = 2'd3;

  // One dictionary word, character 0 in the low byte.
  typedef logic [MAX_WORD_LEN-1:0][7:0] row_t;

  // Text window state: newest character at index 0, newest prefix at bit 0.
  typedef struct packed {
    logic [MAX_WORD_LEN-1:0][7:0] recent;
    logic [MAX_WORD_LEN:0]        hist;
    logic [CNT_W-1:0]             count;
  } text_ctx_t;

endpackage

// File: design/wbc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module wbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/wbc_match.sv
// Compares one dictionary row against the text window for a single slot.
// Depends on wbc_pkg for sizes and the window struct.
module wbc_match (
  input  wbc_pkg::row_t                 row,
  input  logic [wbc_pkg::LEN_W-1:0]     len,
  input  wbc_pkg::text_ctx_t            ctx,
  output logic                          match
);

  logic [wbc_pkg::LEN_W-1:0] hist_idx;
  logic                      chars_ok;

  assign hist_idx = len - wbc_pkg::LEN_W'(1);

  // Window character k lines up with word character len-1-k.
  always_comb begin
    logic [wbc_pkg::LEN_W-1:0] idx;
    chars_ok = 1'b1;
    for (int k = 0; k < wbc_pkg::MAX_WORD_LEN; k++) begin
      idx = hist_idx - wbc_pkg::LEN_W'(k);
      if (wbc_pkg::LEN_W'(k) < len) begin
        if (row[idx[wbc_pkg::POS_W-1:0]] != ctx.recent[k]) begin
          chars_ok = 1'b0;
        end
      end
    end
  end

  assign match = (len != '0)
              && (len <= wbc_pkg::LEN_W'(wbc_pkg::MAX_WORD_LEN))
              && (ctx.count >= wbc_pkg::CNT_W'(len))
              && ctx.hist[hist_idx]
              && chars_ok;

endmodule

// File: design/dictionary_word_break_checker_top.sv
// Dictionary word-break checker: dictionary rows in one RAM, text window in flops.
// Clear and start items finish in ST_IDLE; a load reads the row, then merges the byte
// and writes the row back in ST_LOAD. A text item scans one dictionary row per cycle
// over all 16 slots in ST_SCAN, then its result is registered from ST_DONE and the
// block returns to ST_IDLE for the next item; an untaken result holds it in ST_DONE.
// Synchronous active-low reset clears word lengths, window, history and count;
// the dictionary RAM is not cleared. Depends on wbc_pkg, wbc_ram, wbc_match.
module dictionary_word_break_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_char_value,
  input  logic [3:0]  in_word_slot,
  input  logic [3:0]  in_char_pos,
  input  logic        in_word_end,
  input  logic        in_text_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_breakable,
  output logic [12:0] out_prefix_length,
  output logic        out_is_final
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [wbc_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                       hit_r, hit_nxt;
  logic                       last_r, last_nxt;
  logic [wbc_pkg::POS_W-1:0]  ld_pos_r, ld_pos_nxt;
  logic [7:0]                 ld_char_r, ld_char_nxt;
  wbc_pkg::text_ctx_t         ctx_r, ctx_nxt;
  logic [wbc_pkg::LEN_W-1:0]  len_r [wbc_pkg::MAX_WORDS];
  logic [wbc_pkg::LEN_W-1:0]  len_nxt [wbc_pkg::MAX_WORDS];
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_brk_r, out_brk_nxt;
  logic [12:0]                out_len_r, out_len_nxt;
  logic                       out_fin_r, out_fin_nxt;

  logic                       accept;
  logic                       ram_we;
  logic [wbc_pkg::SLOT_W-1:0] ram_raddr;
  logic [wbc_pkg::SLOT_W-1:0] ram_waddr;
  wbc_pkg::row_t              ram_rdata;
  wbc_pkg::row_t              ram_wdata;
  logic                       slot_match;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // While scanning, the row for slot_r is on the read port and slot_r+1 is fetched.
  always_comb begin
    if (state_r == ST_IDLE) begin
      ram_raddr = (in_command == wbc_pkg::CMD_LOAD) ? in_word_slot : '0;
    end else begin
      ram_raddr = slot_r + wbc_pkg::SLOT_W'(1);
    end
  end

  assign ram_we    = (state_r == ST_LOAD);
  assign ram_waddr = slot_r;

  always_comb begin
    ram_wdata           = ram_rdata;
    ram_wdata[ld_pos_r] = ld_char_r;
  end

  wbc_ram #(
    .WIDTH (wbc_pkg::ROW_W),
    .DEPTH (wbc_pkg::MAX_WORDS)
  ) u_dict_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wbc_match u_match (
    .row   (ram_rdata),
    .len   (len_r[slot_r]),
    .ctx   (ctx_r),
    .match (slot_match)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    hit_nxt       = hit_r;
    last_nxt      = last_r;
    ld_pos_nxt    = ld_pos_r;
    ld_char_nxt   = ld_char_r;
    ctx_nxt       = ctx_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_brk_nxt   = out_brk_r;
    out_len_nxt   = out_len_r;
    out_fin_nxt   = out_fin_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            wbc_pkg::CMD_CLEAR: begin
              for (int w = 0; w < wbc_pkg::MAX_WORDS; w++) begin
                len_nxt[w] = '0;
              end
            end
            wbc_pkg::CMD_LOAD: begin
              slot_nxt    = in_word_slot;
              ld_pos_nxt  = in_char_pos;
              ld_char_nxt = in_char_value;
              if (in_word_end) begin
                len_nxt[in_word_slot] = wbc_pkg::LEN_W'(in_char_pos) + wbc_pkg::LEN_W'(1);
              end
              state_nxt = ST_LOAD;
            end
            wbc_pkg::CMD_START: begin
              ctx_nxt.recent = '0;
              ctx_nxt.hist   = {{wbc_pkg::MAX_WORD_LEN{1'b0}}, 1'b1};
              ctx_nxt.count  = '0;
            end
            wbc_pkg::CMD_TEXT: begin
              for (int j = wbc_pkg::MAX_WORD_LEN - 1; j > 0; j--) begin
                ctx_nxt.recent[j] = ctx_r.recent[j-1];
              end
              ctx_nxt.recent[0] = in_char_value;
              if (ctx_r.count < wbc_pkg::CNT_W'(wbc_pkg::MAX_TEXT)) begin
                ctx_nxt.count = ctx_r.count + wbc_pkg::CNT_W'(1);
              end
              slot_nxt  = '0;
              hit_nxt   = 1'b0;
              last_nxt  = in_text_last;
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        hit_nxt  = hit_r || slot_match;
        slot_nxt = slot_r + wbc_pkg::SLOT_W'(1);
        if (slot_r == wbc_pkg::SLOT_W'(wbc_pkg::MAX_WORDS - 1)) begin
          slot_nxt  = slot_r;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the finished item until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_brk_nxt   = hit_r;
          out_len_nxt   = 13'(ctx_r.count);
          out_fin_nxt   = last_r;
          ctx_nxt.hist  = {ctx_r.hist[wbc_pkg::MAX_WORD_LEN-1:0], hit_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      ctx_r.recent <= '0;
      ctx_r.hist   <= {{wbc_pkg::MAX_WORD_LEN{1'b0}}, 1'b1};
      ctx_r.count  <= '0;
      for (int w = 0; w < wbc_pkg::MAX_WORDS; w++) begin
        len_r[w] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ctx_r       <= ctx_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    hit_r     <= hit_nxt;
    last_r    <= last_nxt;
    ld_pos_r  <= ld_pos_nxt;
    ld_char_r <= ld_char_nxt;
    out_brk_r <= out_brk_nxt;
    out_len_r <= out_len_nxt;
    out_fin_r <= out_fin_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_breakable     = out_brk_r;
  assign out_prefix_length = out_len_r;
  assign out_is_final      = out_fin_r;

  a_load_writes_back: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == wbc_pkg::CMD_LOAD) |=> (ram_we && ram_waddr == $past(in_word_slot)))
    else $error("load item did not write its row back");

  a_text_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == wbc_pkg::CMD_TEXT) |=> (state_r == ST_SCAN && slot_r == '0))
    else $error("text item did not start the scan at slot zero");

  a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == wbc_pkg::CMD_TEXT) |-> ##17 (state_r == ST_DONE))
    else $error("slot scan did not finish in sixteen cycles");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != '0 && out_len_r <= 13'(wbc_pkg::MAX_TEXT)))
    else $error("result prefix length out of range");

  a_start_history: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == wbc_pkg::CMD_START)
      |=> (ctx_r.hist == {{wbc_pkg::MAX_WORD_LEN{1'b0}}, 1'b1}))
    else $error("start item did not reset the history");

endmodule
